@@ sv/swmm_pkg.sv @@
// shared types and constants of the sliding window min/max pixel filter
package swmm_pkg;

    localparam int MAX_RADIUS = 32;
    localparam int WIN_DEPTH  = 64;
    localparam int EFF_RADIUS = (MAX_RADIUS < WIN_DEPTH / 2) ? MAX_RADIUS : WIN_DEPTH / 2;
    localparam int SLOT_W     = $clog2(WIN_DEPTH);

    localparam int RAD_W  = 6;
    localparam int POS_W  = 7;
    localparam int PEND_W = 6;
    localparam int LEN_W  = 7;

    localparam logic [POS_W-1:0] POS_MAX = 7'd127;

    // luma weights, 16-bit fixed point
    localparam logic [15:0] LUMA_KR    = 16'd19589;
    localparam logic [15:0] LUMA_KG    = 16'd38444;
    localparam logic [15:0] LUMA_KB    = 16'd7503;
    localparam logic [23:0] LUMA_ROUND = 24'd32768;

    // configuration register indexes
    localparam logic [1:0] CFG_RADIUS   = 2'd0;
    localparam logic [1:0] CFG_TAKE_MIN = 2'd1;
    localparam logic [1:0] CFG_TARGET   = 2'd2;

    // target channel codes
    localparam logic [1:0] TGT_ALL   = 2'd0;
    localparam logic [1:0] TGT_RGB   = 2'd1;
    localparam logic [1:0] TGT_ALPHA = 2'd2;

    typedef struct packed {
        logic [7:0]  luma;
        logic [31:0] pixel;   // alpha in [31:24], blue, green, red in [7:0]
    } t_cell_data;

    typedef struct packed {
        logic shift;    // new pixel enters at cell 0, all move one place older
        logic rotate;   // ring turns one place toward cell 0
    } t_ring_ctrl;

    typedef struct packed {
        logic valid;
        logic first;
        logic in_win;
        logic is_self;
    } t_head_ctrl;

endpackage

@@ sv/swmm_luma.sv @@
// luma of an incoming pixel: registered weighted products, rounded sum
module swmm_luma (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic [7:0] o_luma
);
    import swmm_pkg::*;

    logic [22:0] r_prod_r;
    logic [23:0] r_prod_g;
    logic [20:0] r_prod_b;
    logic [23:0] w_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_r <= 23'(24'(LUMA_KR) * 24'(i_red));
            r_prod_g <= 24'(LUMA_KG) * 24'(i_green);
            r_prod_b <= 21'(24'(LUMA_KB) * 24'(i_blue));
        end
    end

    // the sum never exceeds 255 * 65536 + 32768, so 24 bits hold it
    assign w_sum  = 24'(r_prod_r) + r_prod_g + 24'(r_prod_b) + LUMA_ROUND;
    assign o_luma = w_sum[23:16];

endmodule

@@ sv/swmm_cell.sv @@
// one window cell: holds a pixel and its luma, shifts in or rotates along the ring
module swmm_cell (
    input  logic                   i_clk,
    input  swmm_pkg::t_ring_ctrl   i_ctrl,
    input  swmm_pkg::t_cell_data   i_prev,
    input  swmm_pkg::t_cell_data   i_next,
    output swmm_pkg::t_cell_data   o_data
);
    import swmm_pkg::*;

    t_cell_data r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_data <= i_prev;
        end else if (i_ctrl.rotate) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

@@ sv/swmm_head.sv @@
// head of the ring: running extreme of luma and alpha, and capture of the center pixel
module swmm_head (
    input  logic                 i_clk,
    input  swmm_pkg::t_head_ctrl i_ctrl,
    input  logic                 i_take_min,
    input  swmm_pkg::t_cell_data i_head,
    output logic [23:0]          o_best_rgb,
    output logic [7:0]           o_best_alpha,
    output logic [31:0]          o_self
);
    import swmm_pkg::*;

    logic [7:0]  r_best_luma;
    logic [23:0] r_best_rgb;
    logic [7:0]  r_best_alpha;
    logic [31:0] r_self;
    logic [7:0]  w_alpha;
    logic        w_luma_wins;
    logic        w_alpha_wins;

    assign w_alpha = i_head.pixel[31:24];

    // cells arrive newest first, so only a strictly better one replaces the best
    assign w_luma_wins  = i_take_min ? (i_head.luma < r_best_luma) : (i_head.luma > r_best_luma);
    assign w_alpha_wins = i_take_min ? (w_alpha < r_best_alpha) : (w_alpha > r_best_alpha);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.valid && i_ctrl.in_win) begin
            if (i_ctrl.first || w_luma_wins) begin
                r_best_luma <= i_head.luma;
                r_best_rgb  <= i_head.pixel[23:0];
            end
            if (i_ctrl.first || w_alpha_wins) begin
                r_best_alpha <= w_alpha;
            end
        end
        if (i_ctrl.valid && i_ctrl.is_self) begin
            r_self <= i_head.pixel;
        end
    end

    assign o_best_rgb   = r_best_rgb;
    assign o_best_alpha = r_best_alpha;
    assign o_self       = r_self;

endmodule

@@ sv/sliding_window_min_max_pixel_filter.sv @@
// top level: input handshake, line control, ring of window cells and output register
// radius 0 (pass through): a taken item goes from the push state to the emit state, which loads
//   it into the output register. radius > 0: a taken item is pushed into the ring; each result
//   then costs one full turn of the 64-cell ring in the scan state plus loading the output.
//   an item owing n results holds the input until all n are loaded, which an output stall delays;
//   n is 0 or 1 mid-line and up to the radius at line end.
// reset (synchronous, active low) clears config, line counters and valid flags; the
//   window cells hold no reset value and only cells written in the current line are used.
module sliding_window_min_max_pixel_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
    input  logic        i_s_axis_tlast,   // line_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic        o_m_axis_tlast,   // line_done
    output logic        o_m_axis_tuser,   // run_last
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);
    import swmm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [RAD_W-1:0]  r_radius;
    logic              r_take_min;
    logic [1:0]        r_target;
    logic [31:0]       r_px;
    logic              r_end;
    logic [POS_W-1:0]  r_line_pos, n_line_pos;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [RAD_W-1:0]  r_line_rad, n_line_rad;
    logic              r_pass, n_pass;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic              r_ovalid, n_ovalid;
    logic [31:0]       r_odata, n_odata;
    logic              r_olast, n_olast;
    logic              r_ouser, n_ouser;

    logic              w_s_acc;
    logic [7:0]        w_luma;
    logic [RAD_W-1:0]  w_eff;
    logic [RAD_W-1:0]  w_rad_now;
    logic [POS_W-1:0]  w_pos_inc;
    logic [PEND_W-1:0] w_pend_inc;
    logic [PEND_W-1:0] w_pend_dec;
    logic [LEN_W-1:0]  w_x;
    logic [LEN_W-1:0]  w_back;
    logic [LEN_W-1:0]  w_len;
    logic              w_out_free;
    logic              w_fc;
    logic              w_fa;
    logic [31:0]       w_res;
    logic [23:0]       w_best_rgb;
    logic [7:0]        w_best_alpha;
    logic [31:0]       w_self;
    t_ring_ctrl        w_ring;
    t_head_ctrl        w_head;
    t_cell_data        w_new;
    t_cell_data        w_cell [WIN_DEPTH];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc         = i_s_axis_tvalid && (r_state == ST_IDLE);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= '0;
            r_take_min <= 1'b0;
            r_target   <= TGT_ALL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS:   r_radius   <= i_cfg_data;
                CFG_TAKE_MIN: r_take_min <= i_cfg_data[0];
                CFG_TARGET:   r_target   <= i_cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_px  <= i_s_axis_tdata;
            r_end <= i_s_axis_tlast;
        end
    end

    swmm_luma u_luma (
        .i_clk   (i_clk),
        .i_en    (w_s_acc),
        .i_red   (i_s_axis_tdata[7:0]),
        .i_green (i_s_axis_tdata[15:8]),
        .i_blue  (i_s_axis_tdata[23:16]),
        .o_luma  (w_luma)
    );

    assign w_eff      = (r_radius > RAD_W'(EFF_RADIUS)) ? RAD_W'(EFF_RADIUS) : r_radius;
    assign w_rad_now  = (r_line_pos == '0) ? w_eff : r_line_rad;
    assign w_pos_inc  = (r_line_pos == POS_MAX) ? r_line_pos : r_line_pos + POS_W'(1);
    assign w_pend_inc = r_pend + PEND_W'(1);
    assign w_pend_dec = r_pend - PEND_W'(1);

    // window of the output owed: ring places 0 (newest) up to w_len - 1
    assign w_x    = r_line_pos - LEN_W'(r_pend);
    assign w_back = (w_x < LEN_W'(r_line_rad)) ? w_x : LEN_W'(r_line_rad);
    assign w_len  = LEN_W'(r_pend) + w_back;

    assign w_ring.shift  = (r_state == ST_PUSH) && (w_rad_now != '0);
    assign w_ring.rotate = (r_state == ST_SCAN);

    assign w_head.valid   = (r_state == ST_SCAN);
    assign w_head.first   = (r_cnt == '0);
    assign w_head.in_win  = (LEN_W'(r_cnt) < w_len);
    assign w_head.is_self = (r_cnt == SLOT_W'(w_pend_dec));

    assign w_new.luma  = w_luma;
    assign w_new.pixel = r_px;

    for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_ring
        t_cell_data w_prev;
        if (g == 0) begin : g_first
            assign w_prev = w_new;
        end else begin : g_rest
            assign w_prev = w_cell[g-1];
        end
        swmm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ring),
            .i_prev (w_prev),
            .i_next (w_cell[(g + 1) % WIN_DEPTH]),
            .o_data (w_cell[g])
        );
    end

    swmm_head u_head (
        .i_clk        (i_clk),
        .i_ctrl       (w_head),
        .i_take_min   (r_take_min),
        .i_head       (w_cell[0]),
        .o_best_rgb   (w_best_rgb),
        .o_best_alpha (w_best_alpha),
        .o_self       (w_self)
    );

    assign w_fc  = (r_target == TGT_ALL) || (r_target == TGT_RGB);
    assign w_fa  = (r_target == TGT_ALL) || (r_target == TGT_ALPHA);
    assign w_res = {w_fa ? w_best_alpha : w_self[31:24], w_fc ? w_best_rgb : w_self[23:0]};

    assign w_out_free = !r_ovalid || i_m_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_line_pos = r_line_pos;
        n_pend     = r_pend;
        n_line_rad = r_line_rad;
        n_pass     = r_pass;
        n_cnt      = r_cnt;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_odata    = r_odata;
        n_olast    = r_olast;
        n_ouser    = r_ouser;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                n_line_rad = w_rad_now;
                if (w_rad_now == '0) begin
                    n_pass     = 1'b1;
                    n_line_pos = r_end ? '0 : w_pos_inc;
                    n_state    = ST_EMIT;
                end else begin
                    n_pass     = 1'b0;
                    n_line_pos = w_pos_inc;
                    n_pend     = w_pend_inc;
                    if ((w_pend_inc >= w_rad_now) || r_end) begin
                        n_cnt   = '0;
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + SLOT_W'(1);
                if (r_cnt == SLOT_W'(WIN_DEPTH - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    if (r_pass) begin
                        n_odata = r_px;
                        n_olast = r_end;
                        n_ouser = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_pend  = w_pend_dec;
                        n_odata = w_res;
                        n_olast = r_end && (w_pend_dec == '0);
                        n_ouser = (w_pend_dec == '0) || !r_end;
                        if (r_end && (w_pend_dec != '0)) begin
                            // flush the next owed output of the line
                            n_cnt   = '0;
                            n_state = ST_SCAN;
                        end else begin
                            if (r_end) begin
                                n_line_pos = '0;
                            end
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_line_pos <= '0;
            r_pend     <= '0;
            r_line_rad <= '0;
            r_pass     <= 1'b0;
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_line_pos <= n_line_pos;
            r_pend     <= n_pend;
            r_line_rad <= n_line_rad;
            r_pass     <= n_pass;
            r_cnt      <= n_cnt;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_ouser <= n_ouser;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_ouser;

endmodule

@@ tb/minmax_filter_checker.sv @@
// checker for the min/max pixel filter: predicts each filtered pixel and compares it
module minmax_filter_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,    // red, green, blue, alpha
    input  logic        i_in_last,    // line_end
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // red, green, blue, alpha
    input  logic        i_out_last,   // line_done
    input  logic        i_out_user,   // run_last
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import swmm_pkg::*;

    typedef struct packed {
        logic [31:0] pixel;       // alpha, blue, green, red
        logic        line_done;
        logic        run_last;
    } t_filt_out;

    t_filt_out   owed_pixels[$];
    t_filt_out   want;
    int          fail_count = 0;

    logic [31:0] win_px[WIN_DEPTH];
    logic [7:0]  win_luma[WIN_DEPTH];
    int unsigned line_pos;
    int unsigned pending;
    int unsigned wr_slot;
    int unsigned line_rad;

    logic [5:0]  cfg_radius;
    logic        cfg_take_min;
    logic [1:0]  cfg_target;

    function automatic logic [7:0] luma_of(input logic [31:0] p);
        logic [31:0] acc;
        acc = LUMA_KR * p[7:0] + LUMA_KG * p[15:8] + LUMA_KB * p[23:16] + LUMA_ROUND;
        return acc[23:16];
    endfunction

    // ties go to the newer pixel
    function automatic bit wins(input int unsigned cand, input int unsigned best);
        return cfg_take_min ? (cand <= best) : (cand >= best);
    endfunction

    task automatic filter_pixel(input logic [31:0] px, input logic endl);
        int unsigned x;
        int unsigned back;
        int unsigned span;
        int unsigned first_slot;
        int unsigned own_slot;
        int unsigned bc;
        int unsigned ba;
        int unsigned s;
        logic [31:0] res;
        logic        fc;
        logic        fa;
        t_filt_out   o;

        if (line_pos == 0)
            line_rad = (cfg_radius > EFF_RADIUS) ? EFF_RADIUS : cfg_radius;

        if (line_rad == 0) begin
            o.pixel     = px;
            o.line_done = endl;
            o.run_last  = 1'b1;
            owed_pixels.push_back(o);
            if (endl)
                line_pos = 0;
            else if (line_pos < POS_MAX)
                line_pos++;
            return;
        end

        win_px[wr_slot]   = px;
        win_luma[wr_slot] = luma_of(px);
        wr_slot = (wr_slot + 1) % WIN_DEPTH;
        if (line_pos < POS_MAX)
            line_pos++;
        pending++;

        while (pending > 0 && (pending >= line_rad || endl)) begin
            x          = line_pos - pending;
            back       = (x < line_rad) ? x : line_rad;
            span       = back + pending;
            first_slot = (wr_slot + 2 * WIN_DEPTH - pending - back) % WIN_DEPTH;
            own_slot   = (wr_slot + WIN_DEPTH - pending) % WIN_DEPTH;
            bc = first_slot;
            ba = first_slot;
            for (int k = 1; k < span; k++) begin
                s = (first_slot + k) % WIN_DEPTH;
                if (wins(win_luma[s], win_luma[bc]))
                    bc = s;
                if (wins(win_px[s][31:24], win_px[ba][31:24]))
                    ba = s;
            end
            fc = (cfg_target == TGT_ALL) || (cfg_target == TGT_RGB);
            fa = (cfg_target == TGT_ALL) || (cfg_target == TGT_ALPHA);
            res = win_px[own_slot];
            if (fc)
                res[23:0] = win_px[bc][23:0];
            if (fa)
                res[31:24] = win_px[ba][31:24];
            pending--;
            o.pixel     = res;
            o.line_done = endl && (pending == 0);
            o.run_last  = (pending == 0) || !endl;
            owed_pixels.push_back(o);
        end

        if (endl) begin
            line_pos = 0;
            pending  = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                win_px[i]   = '0;
                win_luma[i] = '0;
            end
            line_pos     = 0;
            pending      = 0;
            wr_slot      = 0;
            line_rad     = 0;
            cfg_radius   = '0;
            cfg_take_min = 1'b0;
            cfg_target   = TGT_ALL;
            owed_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS:   cfg_radius   = i_cfg_data;
                    CFG_TAKE_MIN: cfg_take_min = i_cfg_data[0];
                    CFG_TARGET:   cfg_target   = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                filter_pixel(i_in_data, i_in_last);
            if (i_out_valid && i_out_ready) begin
                if (owed_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output item: data %h last %b user %b",
                                 i_out_data, i_out_last, i_out_user);
                end else begin
                    want = owed_pixels.pop_front();
                    if (i_out_data[7:0] !== want.pixel[7:0] ||
                        i_out_data[15:8] !== want.pixel[15:8] ||
                        i_out_data[23:16] !== want.pixel[23:16] ||
                        i_out_data[31:24] !== want.pixel[31:24] ||
                        i_out_last !== want.line_done ||
                        i_out_user !== want.run_last) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected r %h g %h b %h a %h done %b last %b",
                                     want.pixel[7:0], want.pixel[15:8], want.pixel[23:16],
                                     want.pixel[31:24], want.line_done, want.run_last);
                            $display("          got      r %h g %h b %h a %h done %b last %b",
                                     i_out_data[7:0], i_out_data[15:8], i_out_data[23:16],
                                     i_out_data[31:24], i_out_last, i_out_user);
                        end
                    end
                end
            end
        end
        o_outstanding <= owed_pixels.size();
        o_fail_count  <= fail_count;
    end

endmodule

@@ tb/tb.sv @@
// top of the testbench: clock, reset, pixel lines, config phases and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swmm_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // unmapped register index
    localparam logic [1:0] TGT_NONE  = 2'd3;   // unused target code
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 2000;
    localparam int ITEM_GOAL     = 310;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data  = '0;
    logic        s_last  = 1'b0;
    logic        m_ready = 1'b0;
    logic        cfg_we  = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [5:0]  cfg_data = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        o_m_axis_tuser;

    int          fail_count;
    int          outstanding;
    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    int          sent_pixels   = 0;
    logic [5:0]  cur_radius    = '0;
    logic [31:0] last_px       = '0;
    logic        sink_hold     = 1'b0;
    bit          hold_go       = 1'b0;

    sliding_window_min_max_pixel_filter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    minmax_filter_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_valid),
        .i_in_ready    (o_s_axis_tready),
        .i_in_data     (s_data),
        .i_in_last     (s_last),
        .i_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (m_ready),
        .i_out_data    (o_m_axis_tdata),
        .i_out_last    (o_m_axis_tlast),
        .i_out_user    (o_m_axis_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_ready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
    end

    // one long receiver hold-off so the filter backs up into its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
            1: begin src_idle_pct <= 62; snk_stall_pct <= 0;  end
            2: begin src_idle_pct <= 0;  snk_stall_pct <= 62; end
            default: begin src_idle_pct <= 32; snk_stall_pct <= 32; end
        endcase
    endtask

    task automatic send_pixel(input logic [31:0] px, input logic endl);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        s_last  <= endl;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sent_pixels++;
    endtask

    // wait for all owed pixels, then let a pixel that owes nothing finish entering
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == CFG_RADIUS)
            cur_radius = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [5:0] pick_radius();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 6'd0;
        if (roll < 50)
            return 6'($urandom_range(4, 1));
        if (roll < 80)
            return 6'($urandom_range(12, 5));
        if (roll < 90)
            return 6'd32;
        return 6'($urandom_range(63, 33));
    endfunction

    function automatic logic [31:0] pick_pixel(input logic [31:0] prev);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 32'h0000_0000;
        if (roll < 16)
            return 32'hFFFF_FFFF;
        if (roll < 28)
            return prev;                                   // full tie
        if (roll < 38)
            return {prev[31:24], 24'($urandom)};           // alpha tie
        if (roll < 48)
            return {8'($urandom), prev[23:0]};             // luma tie
        return $urandom;
    endfunction

    // a scanline of random pixels, optionally with config changed halfway
    task automatic send_line(input int len, input bit mid_change);
        logic [31:0] px;
        for (int i = 0; i < len; i++) begin
            if (mid_change && len > 1 && i == len / 2) begin
                settle();
                write_reg(CFG_TAKE_MIN, 6'($urandom_range(1)));
                write_reg(CFG_TARGET, 6'($urandom_range(3)));
                write_reg(CFG_RADIUS, pick_radius());
            end
            px = pick_pixel(last_px);
            last_px = px;
            send_pixel(px, i == len - 1);
        end
    endtask

    initial begin
        int phase;
        int nlines;
        int len;
        int eff;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // radius zero after reset: straight pass
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        settle();
        write_reg(CFG_SPARE, 6'h3F);

        // dilate all channels, ties on luma and alpha
        write_reg(CFG_RADIUS, 6'd2);
        write_reg(CFG_TAKE_MIN, 6'd0);
        write_reg(CFG_TARGET, 6'(TGT_ALL));
        send_pixel(32'h20FF_FFFF, 1'b0);
        send_pixel(32'hFF00_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0080_8080, 1'b1);
        settle();

        // erode rgb only; one-pixel line, then a short one
        write_reg(CFG_TAKE_MIN, 6'd1);
        write_reg(CFG_TARGET, 6'(TGT_RGB));
        send_pixel(32'h7F12_3456, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFF00_0000, 1'b0);
        send_pixel(32'h01FF_FFFF, 1'b1);
        settle();

        // alpha only; radius changed mid-line waits for the next line
        write_reg(CFG_TARGET, 6'(TGT_ALPHA));
        write_reg(CFG_TAKE_MIN, 6'd0);
        send_pixel(32'h1122_3344, 1'b0);
        settle();
        write_reg(CFG_RADIUS, 6'd5);
        write_reg(CFG_TAKE_MIN, 6'd1);
        send_pixel(32'h5566_7788, 1'b0);
        send_pixel(32'h99AA_BBCC, 1'b1);
        settle();

        // unused target code, radius beyond the limit, line shorter than radius
        write_reg(CFG_TARGET, 6'(TGT_NONE));
        write_reg(CFG_RADIUS, 6'd63);
        send_pixel($urandom, 1'b0);
        send_pixel($urandom, 1'b0);
        send_pixel($urandom, 1'b0);
        send_pixel($urandom, 1'b1);
        settle();

        // receiver holds off while the sender keeps offering pixels
        set_idle(0);
        write_reg(CFG_RADIUS, 6'd1);
        write_reg(CFG_TAKE_MIN, 6'd0);
        write_reg(CFG_TARGET, 6'(TGT_ALL));
        hold_go = 1'b1;
        send_line(14, 1'b0);

        phase = 0;
        while (sent_pixels < ITEM_GOAL) begin
            settle();
            set_idle(phase % 4);
            write_reg(CFG_RADIUS, pick_radius());
            write_reg(CFG_TAKE_MIN, 6'($urandom_range(1)));
            write_reg(CFG_TARGET, 6'($urandom_range(3)));
            nlines = $urandom_range(3, 1);
            for (int l = 0; l < nlines; l++) begin
                if (sent_pixels >= ITEM_GOAL)
                    break;
                eff = (cur_radius > EFF_RADIUS) ? EFF_RADIUS : cur_radius;
                if (phase == 2 && l == 0)
                    len = 130;    // past the saturation of the line position
                else
                    len = $urandom_range(2 * eff + 4, 1);
                send_line(len, $urandom_range(3) == 0);
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
